// ----- src/aptp_pkg.sv -----
`timescale 1ns / 1ps

package aptp_pkg;

   // default table size
   localparam int TASK_SLOTS_DEF = 16;

   // field widths
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 4;
   localparam int PRIO_W   = 6;
   localparam int AGED_W   = 8;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SET       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READY     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NOT_READY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_PICK      = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_READY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   // priority limits
   localparam logic signed [PRIO_W-1:0] PRIO_MIN  = -6'sd20;
   localparam logic signed [PRIO_W-1:0] PRIO_MAX  = 6'sd20;
   localparam logic signed [AGED_W-1:0] AGE_FLOOR = -8'sd128;

   // one slot of the priority table
   typedef struct packed {
      logic signed [PRIO_W-1:0] fixed_prio;
      logic signed [AGED_W-1:0] aged_prio;
   } entry_type;

   // sequencer control for the compare and age unit
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

endpackage

// ----- src/aptp_req_if.sv -----
`timescale 1ns / 1ps

interface aptp_req_if import aptp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [SLOT_W-1:0]        task_slot;
   logic signed [PRIO_W-1:0] priority_req;

   modport source (output valid, cmd, task_slot, priority_req, input ready);
   modport sink (input valid, cmd, task_slot, priority_req, output ready);
endinterface

// ----- src/aptp_rsp_if.sv -----
`timescale 1ns / 1ps

interface aptp_rsp_if import aptp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   chosen_slot;

   modport source (output valid, status, chosen_slot, input ready);
   modport sink (input valid, status, chosen_slot, output ready);
endinterface

// ----- src/aptp_prio_mem.sv -----
`timescale 1ns / 1ps

module aptp_prio_mem import aptp_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   localparam int SW = $clog2(TASK_SLOTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [SW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type             mem_ff [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] valid_ff;
   entry_type             rd_raw_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem_ff[rd_addr];
      end
   end

   // never-written entries read back as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

// ----- src/aptp_scan_unit.sv -----
`timescale 1ns / 1ps

module aptp_scan_unit import aptp_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   localparam int SW = $clog2(TASK_SLOTS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scan_ctl_type             ctl,
   input  logic [SW-1:0]            slot,
   input  logic                     slot_ready,
   input  entry_type                entry,
   output logic                     found,
   output logic [SW-1:0]            best_slot,
   output logic signed [PRIO_W-1:0] best_fixed,
   output logic                     age_en,
   output logic signed [AGED_W-1:0] aged_dec
);

   logic                     found_ff, found_in;
   logic [SW-1:0]            best_slot_ff, best_slot_in;
   logic signed [AGED_W-1:0] best_aged_ff, best_aged_in;
   logic signed [PRIO_W-1:0] best_fixed_ff, best_fixed_in;
   logic                     take;

   // strict less-than keeps the first slot in scan order on a tie
   assign take = ctl.sample && slot_ready && (!found_ff || (entry.aged_prio < best_aged_ff));

   always_comb begin
      found_in      = found_ff;
      best_slot_in  = best_slot_ff;
      best_aged_in  = best_aged_ff;
      best_fixed_in = best_fixed_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in      = 1'b1;
         best_slot_in  = slot;
         best_aged_in  = entry.aged_prio;
         best_fixed_in = entry.fixed_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_slot_ff  <= best_slot_in;
      best_aged_ff  <= best_aged_in;
      best_fixed_ff <= best_fixed_in;
   end

   // saturating age step
   assign age_en   = ctl.sample && slot_ready && (entry.aged_prio > AGE_FLOOR);
   assign aged_dec = entry.aged_prio - 8'sd1;

   assign found      = found_ff;
   assign best_slot  = best_slot_ff;
   assign best_fixed = best_fixed_ff;

endmodule

// ----- src/aging_priority_task_picker_core.sv -----
`timescale 1ns / 1ps

// Task picker with aging over TASK_SLOTS slots. Each request is one command: set priority,
// make ready, make not ready, or pick. Lower numbers are more urgent. A pick returns the
// ready slot with the least aged priority (ties go to the first slot in circular order from
// the last picked slot), ages every ready slot by one with a floor at -128, and restores the
// picked slot to its static priority. The block takes one request at a time: set, make ready
// and make not ready raise their response valid after the execute and done states; a pick
// also passes the scan and fix states, where one shared compare and decrement unit
// visits one slot per cycle through the single read port of the priority table. The request
// side is ready again as soon as the response is handed to the output register, so a new
// request can be taken while a response still waits. The table needs no clearing pass after
// reset: per-slot valid bits make unwritten slots read as zero.

module aging_priority_task_picker_core import aptp_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
   input logic              clock,
   input logic              reset,
   aptp_req_if.sink         req_ch,
   aptp_rsp_if.source       rsp_ch
);

   localparam int SW = $clog2(TASK_SLOTS);
   localparam int CW = $clog2(TASK_SLOTS + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic [TASK_SLOTS-1:0]    ready_ff, ready_in;
   logic [SW-1:0]            head_ff, head_in;
   logic [SW-1:0]            addr_ff, addr_in;
   logic [CW-1:0]            issue_cnt_ff, issue_cnt_in;
   logic                     data_vld_ff, data_vld_in;
   logic [SW-1:0]            data_addr_ff, data_addr_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [SLOT_W-1:0]        res_chosen_ff, res_chosen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]        rsp_chosen_ff, rsp_chosen_in;

   // table port
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [SW-1:0] rd_addr;
   entry_type     rd_data;

   // compare and age unit
   scan_ctl_type             scan_ctl;
   logic                     found;
   logic [SW-1:0]            best_slot;
   logic signed [PRIO_W-1:0] best_fixed;
   logic                     age_en;
   logic signed [AGED_W-1:0] aged_dec;

   logic [SW-1:0] slot_idx;
   logic          slot_ok;
   logic          prio_ok;
   logic [SW-1:0] addr_next;
   logic          issue_done;

   aptp_prio_mem #(.TASK_SLOTS(TASK_SLOTS)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   aptp_scan_unit #(.TASK_SLOTS(TASK_SLOTS)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .slot       (data_addr_ff),
      .slot_ready (ready_ff[data_addr_ff]),
      .entry      (rd_data),
      .found      (found),
      .best_slot  (best_slot),
      .best_fixed (best_fixed),
      .age_en     (age_en),
      .aged_dec   (aged_dec)
   );

   // slots beyond the table are ignored
   assign slot_idx = SW'(slot_ff);
   assign slot_ok  = (32'(slot_ff) < 32'(TASK_SLOTS));
   assign prio_ok  = !(prio_ff < PRIO_MIN) && !(prio_ff > PRIO_MAX);

   // circular walk from the scan head
   assign addr_next  = (addr_ff == SW'(TASK_SLOTS - 1)) ? '0 : addr_ff + SW'(1);
   assign issue_done = (issue_cnt_ff == CW'(TASK_SLOTS));

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      prio_in       = prio_ff;
      ready_in      = ready_ff;
      head_in       = head_ff;
      addr_in       = addr_ff;
      issue_cnt_in  = issue_cnt_ff;
      data_vld_in   = 1'b0;
      data_addr_in  = addr_ff;
      res_status_in = res_status_ff;
      res_chosen_in = res_chosen_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      wr_en         = 1'b0;
      wr_addr       = data_addr_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      scan_ctl      = '0;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.cmd;
               slot_in  = req_ch.task_slot;
               prio_in  = req_ch.priority_req;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = STATUS_OK;
            res_chosen_in = '0;
            state_in      = S_DONE;
            case (cmd_ff)
               CMD_SET: begin
                  if (!prio_ok) begin
                     res_status_in = STATUS_RANGE;
                  end else if (slot_ok) begin
                     wr_en   = 1'b1;
                     wr_addr = slot_idx;
                     wr_data = '{fixed_prio: prio_ff,
                                 aged_prio: {{(AGED_W - PRIO_W){prio_ff[PRIO_W-1]}}, prio_ff}};
                  end
               end
               CMD_READY: begin
                  if (slot_ok) begin
                     ready_in[slot_idx] = 1'b1;
                  end
               end
               CMD_NOT_READY: begin
                  if (slot_ok) begin
                     ready_in[slot_idx] = 1'b0;
                  end
               end
               CMD_PICK: begin
                  addr_in        = head_ff;
                  issue_cnt_in   = '0;
                  scan_ctl.clear = 1'b1;
                  state_in       = S_SCAN;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            // read one slot per cycle, compare and age it the cycle after
            if (!issue_done) begin
               rd_en        = 1'b1;
               addr_in      = addr_next;
               issue_cnt_in = issue_cnt_ff + CW'(1);
               data_vld_in  = 1'b1;
            end
            scan_ctl.sample = data_vld_ff;
            if (data_vld_ff && age_en) begin
               wr_en   = 1'b1;
               wr_addr = data_addr_ff;
               wr_data = '{fixed_prio: rd_data.fixed_prio, aged_prio: aged_dec};
            end
            if (issue_done && !data_vld_ff) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            // winner goes back to its static priority and becomes the new head
            if (found) begin
               wr_en         = 1'b1;
               wr_addr       = best_slot;
               wr_data       = '{fixed_prio: best_fixed,
                                 aged_prio: {{(AGED_W - PRIO_W){best_fixed[PRIO_W-1]}},
                                             best_fixed}};
               head_in       = best_slot;
               res_status_in = STATUS_OK;
               res_chosen_in = SLOT_W'(best_slot);
            end else begin
               res_status_in = STATUS_NO_READY;
               res_chosen_in = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_chosen_in = res_chosen_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= '0;
         head_ff      <= '0;
         issue_cnt_ff <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         head_ff      <= head_in;
         issue_cnt_ff <= issue_cnt_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      prio_ff       <= prio_in;
      addr_ff       <= addr_in;
      data_addr_ff  <= data_addr_in;
      res_status_ff <= res_status_in;
      res_chosen_ff <= res_chosen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.chosen_slot = rsp_chosen_ff;

`ifndef NO_ASSERTIONS
   // aging write-back trails the read by one slot, never the same one
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("table read and write hit the same slot");

   // scan never issues more reads than there are slots
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_cnt_ff <= CW'(TASK_SLOTS))
      else $error("scan read count overran the table");

   // a winner must be a ready slot
   a_winner_ready: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIX) && found) |-> ready_ff[best_slot])
      else $error("picked slot is not ready");

   // empty pick reports slot zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_NO_READY)) |-> (rsp_ch.chosen_slot == '0))
      else $error("empty pick reported a nonzero slot");

   // the head moves to the winner right after a successful pick
   a_head_follows: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIX) && found) |=> (head_ff == $past(best_slot)))
      else $error("scan head did not follow the picked slot");
`endif

endmodule
